// File: design/cbpe_pkg.sv
// ----------------------------------------------------------------------------
// Cubic Bezier point evaluator package
// Default widths, register map and pipeline depth shared by the design files.
// ----------------------------------------------------------------------------
package cbpe_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int T_FRAC_BITS_DEF = 16;
    localparam int NUM_REGS        = 8;
    localparam int REG_IDX_BITS    = 3;
    localparam int PIPE_STAGES     = 9;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_P0_X = 3'd0,
        REG_P0_Y = 3'd1,
        REG_P1_X = 3'd2,
        REG_P1_Y = 3'd3,
        REG_P2_X = 3'd4,
        REG_P2_Y = 3'd5,
        REG_P3_X = 3'd6,
        REG_P3_Y = 3'd7
    } t_reg_idx;

endpackage

// File: design/cbpe_t_if.sv
// ----------------------------------------------------------------------------
// Curve parameter channel
// Valid/ready channel carrying one unsigned t value per beat.
// ----------------------------------------------------------------------------
interface cbpe_t_if #(
    parameter int T_FRAC_BITS = cbpe_pkg::T_FRAC_BITS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [T_FRAC_BITS:0]   t_param;

    modport source (output valid, output t_param, input ready);
    modport sink   (input valid, input t_param, output ready);
endinterface

// File: design/cbpe_pt_if.sv
// ----------------------------------------------------------------------------
// Curve point channel
// Valid/ready channel carrying one signed x/y point per beat.
// ----------------------------------------------------------------------------
interface cbpe_pt_if #(
    parameter int COORD_BITS = cbpe_pkg::COORD_BITS_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [COORD_BITS-1:0]   point_x;
    logic signed [COORD_BITS-1:0]   point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// File: design/cubic_bezier_point_eval_core.sv
// ----------------------------------------------------------------------------
// Cubic Bezier point evaluator
// De Casteljau evaluation of a cubic curve at t, x and y in parallel.
// ----------------------------------------------------------------------------
// Usage:
//   Load the four control points through the write port (i_cfg_we, i_cfg_idx,
//   i_cfg_data) while the block is idle. Index order: p0_x, p0_y, p1_x, p1_y,
//   p2_x, p2_y, p3_x, p3_y.
//   Send t on i_param (valid/ready, 16 fraction bits, values above 1.0 are
//   clamped to 1.0). Each t beat yields one point beat on o_point.
//   From accepted t beat to valid point there are three levels of
//   interpolation, each a difference stage, a multiply stage and a
//   round-and-add stage. One beat enters per cycle while not stalled; the
//   multiply stages (one 17x18 product per lerp) set the depth.
//   Each stage holds only while it is full and the stage after it holds, so
//   empty slots close up behind a stalled receiver and the last stage acts
//   as the output register. Nothing is lost or repeated under stall.
//   Synchronous reset empties the pipeline and clears all control points.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval_core #(
    parameter int COORD_BITS  = cbpe_pkg::COORD_BITS_DEF,
    parameter int T_FRAC_BITS = cbpe_pkg::T_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cbpe_pkg::REG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [COORD_BITS-1:0]               i_cfg_data,
    cbpe_t_if.sink                              i_param,
    cbpe_pt_if.source                           o_point
);

    localparam int C     = COORD_BITS;
    localparam int F     = T_FRAC_BITS;
    localparam int TW    = F + 1;
    localparam int DW    = C + 1;
    localparam int PW    = DW + TW + 1;
    localparam int NSTG  = cbpe_pkg::PIPE_STAGES;
    localparam logic [TW-1:0] T_ONE = {1'b1, {F{1'b0}}};
    localparam logic [PW-1:0] HALF  = {{(PW-1){1'b0}}, 1'b1} << (F - 1);

    function automatic logic signed [DW-1:0] f_diff(input logic [C-1:0] a,
                                                    input logic [C-1:0] b);
        return $signed({b[C-1], b}) - $signed({a[C-1], a});
    endfunction

    function automatic logic signed [PW-1:0] f_mul(input logic signed [DW-1:0] d,
                                                   input logic [TW-1:0] t);
        return d * $signed({1'b0, t});
    endfunction

    function automatic logic [C-1:0] f_rnd(input logic signed [PW-1:0] p,
                                           input logic [C-1:0] a);
        logic [PW-1:0]        s;
        logic signed [PW-1:0] q;
        s = p + HALF;
        q = $signed(s) >>> F;
        return a + q[C-1:0];
    endfunction

    // control points, [axis][point], axis 0 is x
    logic [C-1:0] r_cp [2][4];

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] adv;

    logic [TW-1:0]          t_sat;
    logic [TW-1:0]          r_t0, r_t1, r_t2, r_t3, r_t4, r_t5, r_t6;

    logic signed [DW-1:0]   r_d1 [2][3];
    logic [C-1:0]           r_a1 [2][3];
    logic signed [PW-1:0]   r_m1 [2][3];
    logic [C-1:0]           r_b1 [2][3];
    logic [C-1:0]           r_l1 [2][3];

    logic signed [DW-1:0]   r_d2 [2][2];
    logic [C-1:0]           r_a2 [2][2];
    logic signed [PW-1:0]   r_m2 [2][2];
    logic [C-1:0]           r_b2 [2][2];
    logic [C-1:0]           r_l2 [2][2];

    logic signed [DW-1:0]   r_d3 [2];
    logic [C-1:0]           r_a3 [2];
    logic signed [PW-1:0]   r_m3 [2];
    logic [C-1:0]           r_b3 [2];
    logic [C-1:0]           r_pt [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 2; a++) begin
                for (int p = 0; p < 4; p++) begin
                    r_cp[a][p] <= '0;
                end
            end
        end else if (i_cfg_we) begin
            unique case (cbpe_pkg::t_reg_idx'(i_cfg_idx))
                cbpe_pkg::REG_P0_X: r_cp[0][0] <= i_cfg_data;
                cbpe_pkg::REG_P0_Y: r_cp[1][0] <= i_cfg_data;
                cbpe_pkg::REG_P1_X: r_cp[0][1] <= i_cfg_data;
                cbpe_pkg::REG_P1_Y: r_cp[1][1] <= i_cfg_data;
                cbpe_pkg::REG_P2_X: r_cp[0][2] <= i_cfg_data;
                cbpe_pkg::REG_P2_Y: r_cp[1][2] <= i_cfg_data;
                cbpe_pkg::REG_P3_X: r_cp[0][3] <= i_cfg_data;
                cbpe_pkg::REG_P3_Y: r_cp[1][3] <= i_cfg_data;
            endcase
        end
    end

    // a stage moves on when empty or when the stage after it moves on
    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || o_point.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign i_param.ready = adv[0];
    assign t_sat = (i_param.t_param[F] && (|i_param.t_param[F-1:0])) ? T_ONE
                                                                      : i_param.t_param;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_param.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_t0 <= t_sat;
            for (int a = 0; a < 2; a++) begin
                for (int i = 0; i < 3; i++) begin
                    r_d1[a][i] <= f_diff(r_cp[a][i], r_cp[a][i+1]);
                    r_a1[a][i] <= r_cp[a][i];
                end
            end
        end
        if (adv[1]) begin
            r_t1 <= r_t0;
            for (int a = 0; a < 2; a++) begin
                for (int i = 0; i < 3; i++) begin
                    r_m1[a][i] <= f_mul(r_d1[a][i], r_t0);
                    r_b1[a][i] <= r_a1[a][i];
                end
            end
        end
        if (adv[2]) begin
            r_t2 <= r_t1;
            for (int a = 0; a < 2; a++) begin
                for (int i = 0; i < 3; i++) begin
                    r_l1[a][i] <= f_rnd(r_m1[a][i], r_b1[a][i]);
                end
            end
        end
        if (adv[3]) begin
            r_t3 <= r_t2;
            for (int a = 0; a < 2; a++) begin
                for (int i = 0; i < 2; i++) begin
                    r_d2[a][i] <= f_diff(r_l1[a][i], r_l1[a][i+1]);
                    r_a2[a][i] <= r_l1[a][i];
                end
            end
        end
        if (adv[4]) begin
            r_t4 <= r_t3;
            for (int a = 0; a < 2; a++) begin
                for (int i = 0; i < 2; i++) begin
                    r_m2[a][i] <= f_mul(r_d2[a][i], r_t3);
                    r_b2[a][i] <= r_a2[a][i];
                end
            end
        end
        if (adv[5]) begin
            r_t5 <= r_t4;
            for (int a = 0; a < 2; a++) begin
                for (int i = 0; i < 2; i++) begin
                    r_l2[a][i] <= f_rnd(r_m2[a][i], r_b2[a][i]);
                end
            end
        end
        if (adv[6]) begin
            r_t6 <= r_t5;
            for (int a = 0; a < 2; a++) begin
                r_d3[a] <= f_diff(r_l2[a][0], r_l2[a][1]);
                r_a3[a] <= r_l2[a][0];
            end
        end
        if (adv[7]) begin
            for (int a = 0; a < 2; a++) begin
                r_m3[a] <= f_mul(r_d3[a], r_t6);
                r_b3[a] <= r_a3[a];
            end
        end
        if (adv[8]) begin
            for (int a = 0; a < 2; a++) begin
                r_pt[a] <= f_rnd(r_m3[a], r_b3[a]);
            end
        end
    end

    assign o_point.valid   = r_vld[NSTG-1];
    assign o_point.point_x = r_pt[0];
    assign o_point.point_y = r_pt[1];

endmodule
